// ===== rtl/hbse_pkg.sv =====
// shared types, mode codes and codeword helpers for the hamming byte stream encoder
`default_nettype none

package hbse_pkg;

    localparam int CW_W       = 71;   // longest codeword, 64 data bits
    localparam int WORD_W     = 64;   // data word carried to the back end
    localparam int MODE_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int OBYTE_W    = 7;

    localparam logic [MODE_W-1:0] MODE_D8  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_D12 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_D16 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_D32 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_D64 = 3'd4;

    localparam logic [1:0] PAIR_ONE = 2'd1;
    localparam logic [1:0] PAIR_TWO = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] data;
    } hbse_job_t;

    typedef struct packed {
        logic      valid;
        hbse_job_t job;
    } hbse_slot_t;

    function automatic logic [6:0] data_bits(input logic [MODE_W-1:0] mode);
        logic [6:0] d;
        unique case (mode)
            MODE_D8:  d = 7'd8;
            MODE_D12: d = 7'd12;
            MODE_D16: d = 7'd16;
            MODE_D32: d = 7'd32;
            MODE_D64: d = 7'd64;
            default:  d = 7'd127;
        endcase
        return d;
    endfunction

    function automatic logic [6:0] cw_len(input logic [MODE_W-1:0] mode);
        logic [6:0] n;
        unique case (mode)
            MODE_D8:  n = 7'd12;
            MODE_D12: n = 7'd17;
            MODE_D16: n = 7'd21;
            MODE_D32: n = 7'd38;
            MODE_D64: n = 7'd71;
            default:  n = 7'd0;
        endcase
        return n;
    endfunction

    // output bytes per codeword (all chunks are full in every mode)
    function automatic logic [6:0] cw_bytes(input logic [MODE_W-1:0] mode);
        logic [6:0] b;
        unique case (mode)
            MODE_D8:  b = 7'd2;
            MODE_D12: b = 7'd17;
            MODE_D16: b = 7'd3;
            MODE_D32: b = 7'd19;
            MODE_D64: b = 7'd71;
            default:  b = 7'd0;
        endcase
        return b;
    endfunction

    // position 1 lands in the msb; positions past the length stay zero
    function automatic logic [CW_W-1:0] build_codeword(input logic [MODE_W-1:0] mode,
                                                       input logic [WORD_W-1:0] data);
        logic [CW_W-1:0] cw;
        logic [6:0]      d;
        logic [6:0]      n;
        int              k;
        logic            par;
        cw  = '0;
        d   = data_bits(mode);
        n   = cw_len(mode);
        k   = 0;
        par = 1'b0;
        for (int pos = 1; pos <= CW_W; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                if (pos <= int'(n))
                begin
                    cw[CW_W-pos] = data[6'(int'(d) - 1 - k)];
                end
                k++;
            end
        end
        for (int p = 1; p <= 64; p = p * 2)
        begin
            par = 1'b0;
            for (int j = 1; j <= CW_W; j++)
            begin
                if (((j & p) != 0) && (j != p))
                begin
                    par = par ^ cw[CW_W-j];
                end
            end
            cw[CW_W-p] = par;
        end
        return cw;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hbse_byte_if.sv =====
// byte channel and result channel interfaces
`default_nettype none

interface hbse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hbse_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] first_out_byte;
    logic [6:0] second_out_byte;
    logic [1:0] pair_count;
    logic       codeword_end;

    modport source (output valid, output first_out_byte, output second_out_byte,
                    output pair_count, output codeword_end, input ready);
    modport sink   (input valid, input first_out_byte, input second_out_byte,
                    input pair_count, input codeword_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/hbse_front.sv =====
// front end: mode register, byte collection and codeword job generation
`default_nettype none

module hbse_front
    import hbse_pkg::*;
#(
    parameter int MAX_DATA_BITS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [MODE_W-1:0] cfg_wdata,
    hbse_byte_if.sink              in_ch,
    input  wire logic              q_full,
    output hbse_slot_t             push
);

    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [MAX_DATA_BITS-1:0] collect_reg, collect_next;
    logic [6:0]               bits_reg, bits_next;
    logic [3:0]               held_nibble_reg, held_nibble_next;
    logic                     nibble_pending_reg, nibble_pending_next;

    logic                         accept;
    logic                         mode_ok;
    logic [MAX_DATA_BITS+7:0]     shifted;
    logic [6:0]                   bits_sum;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign mode_ok     = (mode_reg <= MODE_D64) &&
                         (data_bits(mode_reg) <= 7'(MAX_DATA_BITS));
    assign shifted     = {collect_reg, in_ch.data_byte};
    assign bits_sum    = bits_reg + 7'd8;

    always_comb
    begin
        mode_next           = mode_reg;
        collect_next        = collect_reg;
        bits_next           = bits_reg;
        held_nibble_next    = held_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        push                = '0;
        push.job.mode       = mode_reg;
        if (cfg_we)
        begin
            mode_next           = cfg_wdata;
            collect_next        = '0;
            bits_next           = '0;
            held_nibble_next    = '0;
            nibble_pending_next = 1'b0;
        end
        else if (accept && mode_ok)
        begin
            if (mode_reg == MODE_D12)
            begin
                if (nibble_pending_reg)
                begin
                    push.valid          = 1'b1;
                    push.job.data       = WORD_W'({held_nibble_reg, in_ch.data_byte});
                    collect_next        = '0;
                    bits_next           = '0;
                    held_nibble_next    = '0;
                    nibble_pending_next = 1'b0;
                end
                else if (bits_reg == 7'd0)
                begin
                    collect_next = MAX_DATA_BITS'(in_ch.data_byte);
                    bits_next    = 7'd8;
                end
                else
                begin
                    // second byte splits: high nibble closes this word, low nibble waits
                    push.valid          = 1'b1;
                    push.job.data       = WORD_W'({collect_reg[7:0], in_ch.data_byte[7:4]});
                    collect_next        = '0;
                    bits_next           = '0;
                    held_nibble_next    = in_ch.data_byte[3:0];
                    nibble_pending_next = 1'b1;
                end
            end
            else
            begin
                collect_next = shifted[MAX_DATA_BITS-1:0];
                bits_next    = bits_sum;
                if (bits_sum >= data_bits(mode_reg))
                begin
                    push.valid    = 1'b1;
                    push.job.data = WORD_W'(shifted[MAX_DATA_BITS-1:0]);
                    collect_next  = '0;
                    bits_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_D8;
            collect_reg        <= '0;
            bits_reg           <= '0;
            held_nibble_reg    <= '0;
            nibble_pending_reg <= 1'b0;
        end
        else
        begin
            mode_reg           <= mode_next;
            collect_reg        <= collect_next;
            bits_reg           <= bits_next;
            held_nibble_reg    <= held_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
        end
    end

    a_nibble_only_d12: assert property (@(posedge clk) disable iff (!rst_n)
        nibble_pending_reg |-> (bits_reg == 7'd0) && (mode_reg == MODE_D12))
        else $error("held nibble outside twelve-bit mode or with bits collected");

endmodule

`default_nettype wire

// ===== rtl/hbse_queue.sv =====
// two-entry job queue between the front and back ends
`default_nettype none

module hbse_queue
    import hbse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  hbse_slot_t      push,
    output logic            full,
    input  wire logic       pop,
    output hbse_slot_t      head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbse_job_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("codeword job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/hbse_back.sv =====
// back end: builds the codeword and sends it out in chunk pairs
`default_nettype none

module hbse_back
    import hbse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  hbse_slot_t      head,
    output logic            pop,
    hbse_result_if.source   out_ch
);

    logic [CW_W-1:0]    cw_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [6:0]         left_reg;
    logic               busy_reg;

    logic               out_valid_reg;
    logic [OBYTE_W-1:0] first_reg, second_reg;
    logic [1:0]         pair_reg;
    logic               end_reg;

    logic               can_emit, emit, last, load;
    logic [OBYTE_W-1:0] first_chunk, second_chunk;
    logic [3:0]         shift_amt;

    assign can_emit = !out_valid_reg || out_ch.ready;
    assign emit     = busy_reg && can_emit;
    assign last     = emit && (left_reg <= 7'd2);
    assign load     = head.valid && (!busy_reg || last);
    assign pop      = load;

    always_comb
    begin
        unique case (mode_reg)
            MODE_D8:
            begin
                first_chunk  = {1'b0, cw_reg[70:65]};
                second_chunk = {1'b0, cw_reg[64:59]};
                shift_amt    = 4'd12;
            end
            MODE_D12, MODE_D64:
            begin
                first_chunk  = {6'b0, cw_reg[70]};
                second_chunk = {6'b0, cw_reg[69]};
                shift_amt    = 4'd2;
            end
            MODE_D16:
            begin
                first_chunk  = cw_reg[70:64];
                second_chunk = cw_reg[63:57];
                shift_amt    = 4'd14;
            end
            MODE_D32:
            begin
                first_chunk  = {5'b0, cw_reg[70:69]};
                second_chunk = {5'b0, cw_reg[68:67]};
                shift_amt    = 4'd4;
            end
            default:
            begin
                first_chunk  = '0;
                second_chunk = '0;
                shift_amt    = 4'd0;
            end
        endcase
    end

    // codeword shift register, byte counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            mode_reg      <= MODE_D8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mode_reg <= head.job.mode;
                left_reg <= cw_bytes(head.job.mode);
                busy_reg <= 1'b1;
            end
            else if (emit)
            begin
                left_reg <= left_reg - 7'd2;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cw_reg <= build_codeword(head.job.mode, head.job.data);
        end
        else if (emit)
        begin
            cw_reg <= cw_reg << shift_amt;
        end
        if (emit)
        begin
            first_reg  <= first_chunk;
            second_reg <= (left_reg == 7'd1) ? '0 : second_chunk;
            pair_reg   <= (left_reg == 7'd1) ? PAIR_ONE : PAIR_TWO;
            end_reg    <= (left_reg <= 7'd2);
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.first_out_byte  = first_reg;
    assign out_ch.second_out_byte = second_reg;
    assign out_ch.pair_count      = pair_reg;
    assign out_ch.codeword_end    = end_reg;

    a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != 7'd0))
        else $error("codeword in progress with no bytes left");

    a_single_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (pair_reg == PAIR_ONE)) |-> end_reg && (second_reg == '0))
        else $error("single-byte result that does not close its codeword");

    a_load_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |=> out_valid_reg && end_reg)
        else $error("new codeword loaded before the last one was finished");

endmodule

`default_nettype wire

// ===== rtl/hamming_byte_stream_encoder.sv =====
// top level of the hamming byte stream encoder
`default_nettype none

// Hamming SEC encoder for a byte stream. Bytes arrive on in_ch, msb first, and are
// gathered into codewords of 8, 12, 16, 32 or 64 data bits as the mode register selects
// (written through cfg_we/cfg_wdata while idle; a write clears any partial word).
// The front end takes one byte per cycle while the two-entry job queue has room;
// the back end builds the codeword as it loads a job and then, unless out_ch stalls,
// emits one result (two chunk bytes, or one to close an odd count) per cycle, so a
// codeword gives 1, 9, 2, 10 or 36 results for the five modes. The output channel
// sets the sustained rate: in 64-bit mode 8 bytes give 36 results.
// Partial codewords are held until completed, never emitted.
module hamming_byte_stream_encoder
    import hbse_pkg::*;
#(
    parameter int MAX_DATA_BITS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [MODE_W-1:0] cfg_wdata,
    hbse_byte_if.sink              in_ch,
    hbse_result_if.source          out_ch
);

    hbse_slot_t push;
    hbse_slot_t head;
    logic       q_full;
    logic       pop;

    hbse_front #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push)
    );

    hbse_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    hbse_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
